FILE: design/rtlc_pkg.sv
`timescale 1ns / 1ps
package rtlc_pkg;

	localparam int SLOTS_DEF      = 8;
	localparam int CATEGORIES_DEF = 64;

	localparam int CMD_W   = 3;
	localparam int ID_W    = 31;
	localparam int CAT_W   = 6;
	localparam int LEVEL_W = 16;

	// command codes
	localparam logic [CMD_W-1:0] CMD_REGISTER   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_UNREGISTER = 3'd1;
	localparam logic [CMD_W-1:0] CMD_UNREG_ALL  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_IS_LISTED  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_IS_TOP     = 3'd4;
	localparam logic [CMD_W-1:0] CMD_SECOND     = 3'd5;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [ID_W-1:0]    entity_id;
		logic [CAT_W-1:0]   category;
		logic [LEVEL_W-1:0] level;
		logic [ID_W-1:0]    person_id;
	} in_item_t;

	typedef struct packed {
		logic            ok;
		logic [ID_W-1:0] holder_id;
	} out_item_t;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [LEVEL_W-1:0] level;
		logic [ID_W-1:0]    person;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_INSERT,
		ST_DELETE,
		ST_DEL_LAST,
		ST_NEXT,
		ST_DONE
	} state_t;

endpackage

FILE: design/rtlc_chan.sv
`timescale 1ns / 1ps
interface rtlc_chan #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/rtlc_store.sv
`timescale 1ns / 1ps
module rtlc_store #(
	parameter int DEPTH = rtlc_pkg::SLOTS_DEF * rtlc_pkg::CATEGORIES_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output rtlc_pkg::slot_t     rd_data,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  rtlc_pkg::slot_t     wr_data
);

	rtlc_pkg::slot_t mem [DEPTH];
	rtlc_pkg::slot_t rd_data_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: design/ranked_top_list_per_category.sv
`timescale 1ns / 1ps
// Ranked top lists, one list of SLOTS entries per category, in a slot memory.
// Channels: req (sink) carries command, entity_id, category, level, person_id;
// rsp (source) carries ok and holder_id, one result per accepted command.
// An item transfers when valid and ready are both high.
// Operation: each command reads its category's slots one per cycle through the
// slot memory's read port, then register and unregister shift the tail of
// the list, again one slot per cycle, and the result is then loaded into the
// output register. Unregister-all repeats scan and shift for every category.
// Unknown commands, and other commands with a bad category, skip the scan.
// Reset: after arst_n releases, a clearing pass writes all CATEGORIES * SLOTS
// slots (512 by default) to empty, one slot per cycle; req.ready stays low
// until it ends.
// Stall: a finished result waits in the output register; the next command is
// accepted and worked on meanwhile, and its result waits until rsp frees.
module ranked_top_list_per_category #(
	parameter int SLOTS      = rtlc_pkg::SLOTS_DEF,
	parameter int CATEGORIES = rtlc_pkg::CATEGORIES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rtlc_chan.sink    req,
	rtlc_chan.source  rsp
);

	localparam int DEPTH = SLOTS * CATEGORIES;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = $clog2(SLOTS);
	localparam int CW    = (CATEGORIES > 1) ? $clog2(CATEGORIES) : 1;
	localparam int IW    = rtlc_pkg::ID_W;

	rtlc_pkg::state_t state_q, state_d;

	logic [rtlc_pkg::CMD_W-1:0]   cmd_q;
	logic [IW-1:0]                id_q;
	logic [rtlc_pkg::LEVEL_W-1:0] lvl_q;
	logic [IW-1:0]                per_q;
	logic [CW-1:0]                cat_q;
	logic [SW:0]                  iss_q;
	logic                         rvld_s1;
	logic [SW-1:0]                ridx_s1;
	logic                         listed_q;
	logic [SW-1:0]                hit_q;
	logic                         pos_found_q;
	logic [SW-1:0]                pos_q;
	logic [IW-1:0]                top_q;
	logic [IW-1:0]                second_q;
	rtlc_pkg::slot_t              carry_q;
	logic [AW-1:0]                clr_q;
	logic                         res_ok_q;
	logic [IW-1:0]                res_holder_q;
	logic                         out_vld_q;
	rtlc_pkg::out_item_t          out_q;

	rtlc_pkg::slot_t rd_data;
	rtlc_pkg::slot_t wr_data;
	logic            rd_en, wr_en;
	logic [SW-1:0]   wr_slot;
	logic [AW-1:0]   base, rd_addr, wr_addr;

	logic            accept, cat_ok, scan_last, cur_hit, qual, load_out;
	logic            listed_n, pos_found_n;
	logic [SW-1:0]   hit_n, pos_n;
	logic [IW-1:0]   top_n, second_n;
	logic            last_cat;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == rtlc_pkg::ST_IDLE);
	assign cat_ok   = (int'(req.data.category) < CATEGORIES);
	assign last_cat = (cat_q == CW'(CATEGORIES - 1));
	assign load_out = (state_q == rtlc_pkg::ST_DONE) && (!out_vld_q || rsp.ready);

	// fold the slot arriving from memory into the scan results
	assign scan_last   = rvld_s1 && (ridx_s1 == SW'(SLOTS - 1));
	assign cur_hit     = rvld_s1 && (id_q != '0) && (rd_data.id == id_q);
	assign listed_n    = listed_q || cur_hit;
	assign hit_n       = (cur_hit && !listed_q) ? ridx_s1 : hit_q;
	assign qual        = rvld_s1 && !pos_found_q &&
	                     ((rd_data.id == '0) || (rd_data.level < lvl_q));
	assign pos_found_n = pos_found_q || qual;
	assign pos_n       = qual ? ridx_s1 : pos_q;
	assign top_n       = (rvld_s1 && ridx_s1 == SW'(0)) ? rd_data.id : top_q;
	assign second_n    = (rvld_s1 && ridx_s1 == SW'(1)) ? rd_data.id : second_q;

	// address of the category's first slot
	assign base    = AW'(cat_q) * AW'(SLOTS);
	assign rd_addr = base + AW'(iss_q[SW-1:0]);
	assign wr_addr = (state_q == rtlc_pkg::ST_CLEAR) ? clr_q : base + AW'(wr_slot);

	// next state and memory controls
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		wr_en   = 1'b0;
		wr_slot = '0;
		wr_data = '0;
		case (state_q)
			rtlc_pkg::ST_CLEAR: begin
				wr_en = 1'b1;
				if (clr_q == AW'(DEPTH - 1)) state_d = rtlc_pkg::ST_IDLE;
			end
			rtlc_pkg::ST_IDLE: begin
				if (accept) begin
					if (req.data.command == rtlc_pkg::CMD_UNREG_ALL) begin
						state_d = rtlc_pkg::ST_SCAN;
					end else if (cat_ok && req.data.command <= rtlc_pkg::CMD_SECOND) begin
						state_d = rtlc_pkg::ST_SCAN;
					end else begin
						state_d = rtlc_pkg::ST_DONE;
					end
				end
			end
			rtlc_pkg::ST_SCAN: begin
				rd_en = (iss_q < (SW+1)'(SLOTS));
				if (scan_last) begin
					case (cmd_q)
						rtlc_pkg::CMD_REGISTER: begin
							if (id_q != '0 && !listed_n && pos_found_n)
								state_d = rtlc_pkg::ST_INSERT;
							else
								state_d = rtlc_pkg::ST_DONE;
						end
						rtlc_pkg::CMD_UNREGISTER: begin
							state_d = listed_n ? rtlc_pkg::ST_DELETE : rtlc_pkg::ST_DONE;
						end
						rtlc_pkg::CMD_UNREG_ALL: begin
							state_d = listed_n ? rtlc_pkg::ST_DELETE : rtlc_pkg::ST_NEXT;
						end
						default: state_d = rtlc_pkg::ST_DONE;
					endcase
				end
			end
			rtlc_pkg::ST_INSERT: begin
				rd_en   = (iss_q < (SW+1)'(SLOTS));
				wr_en   = rvld_s1;
				wr_slot = ridx_s1;
				wr_data = carry_q;
				if (scan_last) state_d = rtlc_pkg::ST_DONE;
			end
			rtlc_pkg::ST_DELETE: begin
				rd_en   = (iss_q < (SW+1)'(SLOTS));
				wr_en   = rvld_s1;
				wr_slot = ridx_s1 - SW'(1);
				wr_data = rd_data;
				if (!rd_en && !rvld_s1) state_d = rtlc_pkg::ST_DEL_LAST;
			end
			rtlc_pkg::ST_DEL_LAST: begin
				wr_en   = 1'b1;
				wr_slot = SW'(SLOTS - 1);
				state_d = (cmd_q == rtlc_pkg::CMD_UNREG_ALL) ? rtlc_pkg::ST_NEXT
				                                             : rtlc_pkg::ST_DONE;
			end
			rtlc_pkg::ST_NEXT: begin
				state_d = last_cat ? rtlc_pkg::ST_DONE : rtlc_pkg::ST_SCAN;
			end
			rtlc_pkg::ST_DONE: begin
				if (load_out) state_d = rtlc_pkg::ST_IDLE;
			end
			default: state_d = rtlc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtlc_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers: clear counter, read pipe, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			rvld_s1   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (state_q == rtlc_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
			rvld_s1 <= rd_en;
			if (load_out) out_vld_q <= 1'b1;
			else if (rsp.ready) out_vld_q <= 1'b0;
		end
	end

	// command datapath
	always_ff @(posedge clk) begin
		ridx_s1 <= iss_q[SW-1:0];
		if (rd_en) iss_q <= iss_q + (SW+1)'(1);
		if (load_out) begin
			out_q.ok        <= res_ok_q;
			out_q.holder_id <= res_holder_q;
		end
		case (state_q)
			rtlc_pkg::ST_IDLE: begin
				cmd_q        <= req.data.command;
				id_q         <= req.data.entity_id;
				lvl_q        <= req.data.level;
				per_q        <= req.data.person_id;
				cat_q        <= (req.data.command == rtlc_pkg::CMD_UNREG_ALL) ? '0
				                : CW'(req.data.category);
				iss_q        <= '0;
				listed_q     <= 1'b0;
				pos_found_q  <= 1'b0;
				top_q        <= '0;
				second_q     <= '0;
				hit_q        <= '0;
				pos_q        <= '0;
				res_ok_q     <= 1'b0;
				res_holder_q <= '0;
			end
			rtlc_pkg::ST_SCAN: begin
				listed_q    <= listed_n;
				hit_q       <= hit_n;
				pos_found_q <= pos_found_n;
				pos_q       <= pos_n;
				top_q       <= top_n;
				second_q    <= second_n;
				if (scan_last) begin
					case (cmd_q)
						rtlc_pkg::CMD_REGISTER: begin
							res_ok_q <= (id_q != '0) && !listed_n && pos_found_n;
							iss_q    <= (SW+1)'(pos_n);
							carry_q  <= '{id: id_q, level: lvl_q, person: per_q};
						end
						rtlc_pkg::CMD_UNREGISTER, rtlc_pkg::CMD_UNREG_ALL: begin
							res_ok_q <= listed_n;
							iss_q    <= (SW+1)'(hit_n) + (SW+1)'(1);
						end
						rtlc_pkg::CMD_IS_LISTED: res_ok_q <= listed_n;
						rtlc_pkg::CMD_IS_TOP: res_ok_q <= (id_q != '0) && (top_n == id_q);
						rtlc_pkg::CMD_SECOND: begin
							res_ok_q     <= (second_n != '0);
							res_holder_q <= second_n;
						end
						default: res_ok_q <= 1'b0;
					endcase
				end
			end
			rtlc_pkg::ST_INSERT: begin
				if (rvld_s1) carry_q <= rd_data;
			end
			rtlc_pkg::ST_NEXT: begin
				// restart the scan on the following category
				res_ok_q    <= 1'b1;
				cat_q       <= cat_q + CW'(1);
				iss_q       <= '0;
				listed_q    <= 1'b0;
				pos_found_q <= 1'b0;
				hit_q       <= '0;
			end
			default: begin
			end
		endcase
	end

	rtlc_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;

endmodule

FILE: design/rtlc_checker.sv
`timescale 1ns / 1ps
module rtlc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic                        rsp_ok,
	input logic [rtlc_pkg::ID_W-1:0]   rsp_holder
);

	// hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_ok) && $stable(rsp_holder))
		else $error("stalled result changed");

	// a second holder is reported only with ok set
	a_holder_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_holder != '0 |-> rsp_ok)
		else $error("holder id without ok");

	// one command at a time: busy right after a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("command accepted while busy");

endmodule

bind ranked_top_list_per_category rtlc_checker u_rtlc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_ok     (rsp.data.ok),
	.rsp_holder (rsp.data.holder_id)
);
